/* sv/dsa_pkg.sv */
// Shared types, widths and codes of the descriptor slot allocator.
package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int FREE_IDX_W = 10;
  localparam int SLOT_W     = 10;
  localparam int ADDR_W     = 64;
  localparam int STRIDE_W   = 13;
  localparam int CAP_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 13'd32;
  localparam logic [CAP_W-1:0]    CAPACITY_RST = 11'd1024;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic                  is_free;
    logic                  in_range;
    logic [FREE_IDX_W-1:0] free_index;
  } cmd_t;

endpackage

/* sv/dsa_front.sv */
// Front end: accept request items and classify them into commands.
module dsa_front #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF,
  localparam int ECW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [dsa_pkg::FREE_IDX_W-1:0]   in_free_index,
  input  logic [ECW-1:0]                   eff_cap,
  input  logic                             cmd_full,
  output logic                             cmd_push,
  output dsa_pkg::cmd_t                    cmd_data
);

  assign in_ready = !cmd_full;
  assign cmd_push = in_valid && !cmd_full;

  // Range check against the clamped capacity is done here, once per item.
  always_comb begin
    cmd_data.is_free    = in_mode;
    cmd_data.in_range   = 32'(in_free_index) < 32'(eff_cap);
    cmd_data.free_index = in_free_index;
  end

endmodule

/* sv/dsa_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
module dsa_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dsa_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dsa_pkg::cmd_t pop_data,
  output logic          empty
);

  dsa_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/dsa_back.sv */
// Back end: free-slot FIFO, bump counter, address arithmetic, result register.
module dsa_back #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF,
  localparam int IW  = $clog2(MAX_SLOTS),
  localparam int ECW = $clog2(MAX_SLOTS + 1),
  localparam int OW  = IW + dsa_pkg::STRIDE_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_empty,
  input  dsa_pkg::cmd_t                   cmd_data,
  output logic                            cmd_pop,
  input  logic [dsa_pkg::ADDR_W-1:0]      cpu_base,
  input  logic [dsa_pkg::ADDR_W-1:0]      gpu_base,
  input  logic [dsa_pkg::STRIDE_W-1:0]    stride,
  input  logic                            shader_visible,
  input  logic [ECW-1:0]                  eff_cap,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dsa_pkg::SLOT_W-1:0]      out_slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]      out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]      out_gpu_address,
  output logic [dsa_pkg::STATUS_W-1:0]    out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [IW-1:0]                head_r, head_nxt;
  logic [IW-1:0]                tail_r, tail_nxt;
  logic [ECW-1:0]               count_r, count_nxt;
  logic [ECW-1:0]               fresh_r, fresh_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [OW-1:0]                off_r, off_nxt;
  logic                         res_ok_r, res_ok_nxt;
  logic [dsa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dsa_pkg::SLOT_W-1:0]   out_slot_index_r;
  logic [dsa_pkg::ADDR_W-1:0]   out_cpu_address_r;
  logic [dsa_pkg::ADDR_W-1:0]   out_gpu_address_r;
  logic [dsa_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_load;

  logic [IW-1:0] mem [MAX_SLOTS];
  logic [IW-1:0] rd_q;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_data;

  function automatic logic [IW-1:0] ptr_adv(input logic [IW-1:0] ptr);
    return (ptr == IW'(MAX_SLOTS - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign out_load = (state_r == S_SUM) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    res_ok_nxt     = res_ok_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = IW'(cmd_data.free_index);
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = dsa_pkg::STATUS_OK;
          state_nxt      = S_SUM;
          if (!cmd_data.is_free) begin
            if (count_r != '0) begin
              // take the oldest freed slot
              rd_en      = 1'b1;
              head_nxt   = ptr_adv(head_r);
              count_nxt  = count_r - 1'b1;
              res_ok_nxt = 1'b1;
              state_nxt  = S_READ;
            end else if (fresh_r < eff_cap) begin
              idx_nxt    = IW'(fresh_r);
              fresh_nxt  = fresh_r + 1'b1;
              res_ok_nxt = 1'b1;
              state_nxt  = S_MUL;
            end else begin
              res_status_nxt = dsa_pkg::STATUS_FULL;
            end
          end else if (!cmd_data.in_range || count_r >= eff_cap) begin
            res_status_nxt = dsa_pkg::STATUS_DROPPED;
          end else begin
            wr_en     = 1'b1;
            tail_nxt  = ptr_adv(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
      end
      S_READ: begin
        idx_nxt   = rd_q;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        off_nxt   = OW'(idx_r) * OW'(stride);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    off_r        <= off_nxt;
    res_ok_r     <= res_ok_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      if (res_ok_r) begin
        out_slot_index_r  <= dsa_pkg::SLOT_W'(idx_r);
        out_cpu_address_r <= cpu_base + dsa_pkg::ADDR_W'(off_r);
        out_gpu_address_r <= shader_visible ? gpu_base + dsa_pkg::ADDR_W'(off_r) : '0;
      end else begin
        out_slot_index_r  <= '0;
        out_cpu_address_r <= '0;
        out_gpu_address_r <= '0;
      end
    end
  end

  // Free-slot store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[head_r];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_index  = out_slot_index_r;
  assign out_cpu_address = out_cpu_address_r;
  assign out_gpu_address = out_gpu_address_r;
  assign out_status      = out_status_r;

endmodule

/* sv/descriptor_slot_allocator.sv */
// Top level of the descriptor slot allocator: configuration registers, front, queue, back.
//
// Hands out slot indices from a fixed heap of up to MAX_SLOTS slots. An allocate
// item (in_mode 0) reuses the oldest freed index if any is queued, otherwise the
// next never-used index; the result carries the index, cpu_base + index * stride
// and, when shader_visible is set, gpu_base + index * stride (both wrap at 64
// bits). A free item (in_mode 1) queues in_free_index for reuse. out_status is 0
// for success, 1 when an allocate finds the heap full, 2 when a free is dropped
// because its index is at or beyond the capacity or the free queue already holds
// capacity entries; non-ok results carry zero in every other field. Capacity is
// clamped to MAX_SLOTS. Double frees are not detected. Every item gives exactly
// one result, in order. The back end works on one item at a time: an allocate
// served from the free queue steps through queue memory read, latch, multiply
// and add, a fresh allocate through multiply and add, a free or a heap-full
// result goes straight to the result register. A two-entry command queue
// lets the input side keep accepting while the back end or the output stalls, and
// the result register lets a new item start while a finished one waits. Write the
// cfg_ registers only while no item is in flight; writes take effect at once.
module descriptor_slot_allocator #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [dsa_pkg::FREE_IDX_W-1:0]   in_free_index,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dsa_pkg::SLOT_W-1:0]       out_slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]       out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]       out_gpu_address,
  output logic [dsa_pkg::STATUS_W-1:0]     out_status
);

  localparam int ECW = $clog2(MAX_SLOTS + 1);

  // Configuration registers
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_r;
  logic [dsa_pkg::ADDR_W-1:0]   gpu_base_r;
  logic [dsa_pkg::STRIDE_W-1:0] stride_r;
  logic [dsa_pkg::CAP_W-1:0]    capacity_r;
  logic                         shader_visible_r;
  logic [ECW-1:0]               eff_cap;

  // Front-to-back command path
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_full;
  logic          cmd_empty;
  dsa_pkg::cmd_t cmd_in;
  dsa_pkg::cmd_t cmd_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_base_r       <= '0;
      gpu_base_r       <= '0;
      stride_r         <= dsa_pkg::STRIDE_RST;
      capacity_r       <= dsa_pkg::CAPACITY_RST;
      shader_visible_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsa_pkg::REG_CPU_BASE:       cpu_base_r       <= cfg_wdata;
        dsa_pkg::REG_GPU_BASE:       gpu_base_r       <= cfg_wdata;
        dsa_pkg::REG_STRIDE:         stride_r         <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::REG_CAPACITY:       capacity_r       <= cfg_wdata[dsa_pkg::CAP_W-1:0];
        dsa_pkg::REG_SHADER_VISIBLE: shader_visible_r <= cfg_wdata[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Clamp the programmed capacity to the built depth.
  always_comb begin
    if (32'(capacity_r) > 32'(MAX_SLOTS)) begin
      eff_cap = ECW'(MAX_SLOTS);
    end else begin
      eff_cap = ECW'(capacity_r);
    end
  end

  dsa_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_free_index (in_free_index),
    .eff_cap       (eff_cap),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in)
  );

  dsa_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  dsa_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (cmd_empty),
    .cmd_data        (cmd_out),
    .cmd_pop         (cmd_pop),
    .cpu_base        (cpu_base_r),
    .gpu_base        (gpu_base_r),
    .stride          (stride_r),
    .shader_visible  (shader_visible_r),
    .eff_cap         (eff_cap),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_index  (out_slot_index),
    .out_cpu_address (out_cpu_address),
    .out_gpu_address (out_gpu_address),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  // A failed allocate or a dropped free carries zero payload.
  a_nonok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dsa_pkg::STATUS_OK |->
      out_slot_index == '0 && out_cpu_address == '0 && out_gpu_address == '0)
    else $error("non-ok result with nonzero payload");

  // GPU addresses stay zero while shader visibility is off.
  a_gpu_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !shader_visible_r |-> out_gpu_address == '0)
    else $error("gpu address produced while not shader visible");

  // The front end never pushes into a full command queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_full |-> !cmd_push)
    else $error("command queue overrun");

  // The back end only pops commands that are present.
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command queue underrun");
`endif

endmodule

/* test/descriptor_slot_allocator_tb.sv */
// Self-checking testbench: random and directed allocate/free traffic checked against a slot model.
module descriptor_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsa_pkg::*;

  localparam int SLOT_COUNT    = MAX_SLOTS_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  // Let the back end settle after the last grant before touching cfg.
  localparam int SETTLE_CYCLES = 8;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [FREE_IDX_W-1:0] index;
  } slot_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   cpu_addr;
    logic [ADDR_W-1:0]   gpu_addr;
    logic [STATUS_W-1:0] status;
  } slot_grant_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = MODE_ALLOC;
  logic [FREE_IDX_W-1:0] in_free_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_W-1:0]     out_slot_index;
  logic [ADDR_W-1:0]     out_cpu_address;
  logic [ADDR_W-1:0]     out_gpu_address;
  logic [STATUS_W-1:0]   out_status;

  descriptor_slot_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_free_index  (in_free_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_index (out_slot_index),
    .out_cpu_address(out_cpu_address),
    .out_gpu_address(out_gpu_address),
    .out_status     (out_status)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven, and the grants they are expected to produce.
  slot_req_t   request_q[$];
  slot_grant_t grant_q[$];

  // Shadow copy of the configuration registers.
  logic [ADDR_W-1:0]   cpu_base_r = '0;
  logic [ADDR_W-1:0]   gpu_base_r = '0;
  logic [STRIDE_W-1:0] stride_r = STRIDE_RST;
  logic [CAP_W-1:0]    capacity_r = CAPACITY_RST;
  logic                visible_r = 1'b0;

  // Shadow copy of the free list and the bump counter.
  logic [FREE_IDX_W-1:0] recycled[SLOT_COUNT];
  int unsigned           recycle_rd = 0;
  int unsigned           recycle_wr = 0;
  int unsigned           recycle_cnt = 0;
  int unsigned           fresh_next = 0;

  int  err_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  ready_hold = 0;
  bit  req_taken = 1'b0;
  bit  idle_on = 1'b1;

  // Capacity as the block uses it: anything above the built depth is clamped.
  function automatic int unsigned usable_slots();
    return (32'(capacity_r) > SLOT_COUNT) ? SLOT_COUNT : 32'(capacity_r);
  endfunction

  // Apply one request to the shadow heap and return the grant it must produce.
  function automatic slot_grant_t serve_request(slot_req_t r);
    slot_grant_t g;
    int unsigned lim;
    int unsigned idx;
    bit          got;
    logic [ADDR_W-1:0] offset;
    g = '0;
    got = 1'b0;
    idx = 0;
    lim = usable_slots();
    if (r.mode == MODE_ALLOC) begin
      // Reuse the oldest freed slot first, even one beyond a lowered capacity.
      if (recycle_cnt > 0) begin
        idx = 32'(recycled[recycle_rd]);
        recycle_rd = (recycle_rd + 1) % SLOT_COUNT;
        recycle_cnt--;
        got = 1'b1;
      end else if (fresh_next < lim) begin
        idx = fresh_next;
        fresh_next++;
        got = 1'b1;
      end
      if (got) begin
        offset = 64'(idx) * 64'(stride_r);
        g.slot = idx[SLOT_W-1:0];
        g.cpu_addr = cpu_base_r + offset;
        g.gpu_addr = visible_r ? gpu_base_r + offset : '0;
        g.status = STATUS_OK;
      end else begin
        g.status = STATUS_FULL;
      end
    end else begin
      // Drop frees that are out of range or would overflow the list.
      if (32'(r.index) >= lim || recycle_cnt >= lim) begin
        g.status = STATUS_DROPPED;
      end else begin
        recycled[recycle_wr] = r.index;
        recycle_wr = (recycle_wr + 1) % SLOT_COUNT;
        recycle_cnt++;
        g.status = STATUS_OK;
      end
    end
    return g;
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Write one register on the falling edge; the shadow follows at once since
  // nothing is in flight while the configuration changes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CPU_BASE:       cpu_base_r = val;
      REG_GPU_BASE:       gpu_base_r = val;
      REG_STRIDE:         stride_r = val[STRIDE_W-1:0];
      REG_CAPACITY:       capacity_r = val[CAP_W-1:0];
      REG_SHADER_VISIBLE: visible_r = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] cpu, logic [63:0] gpu, int stride, int cap, bit vis);
    write_reg(REG_CPU_BASE, cpu);
    write_reg(REG_GPU_BASE, gpu);
    write_reg(REG_STRIDE, 64'(stride));
    write_reg(REG_CAPACITY, 64'(cap));
    write_reg(REG_SHADER_VISIBLE, 64'(vis));
  endtask

  task automatic push_req(logic mode, int idx);
    slot_req_t r;
    r.mode = mode;
    r.index = idx[FREE_IDX_W-1:0];
    request_q.push_back(r);
  endtask

  // Random traffic: frees mostly name an in-range slot so the list really
  // fills and drains; one in ten is noise anywhere in the index field.
  task automatic queue_requests(int n, int alloc_pct);
    int unsigned lim;
    slot_req_t   r;
    for (int k = 0; k < n; k++) begin
      lim = usable_slots();
      r.mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
      if (r.mode == MODE_FREE && lim > 0 && $urandom_range(0, 9) != 0)
        r.index = FREE_IDX_W'($urandom_range(0, lim - 1));
      else
        r.index = FREE_IDX_W'($urandom_range(0, SLOT_COUNT - 1));
      request_q.push_back(r);
    end
  endtask

  // Hold until every request is accepted and every grant is back, then settle.
  task automatic wait_idle();
    do @(negedge clk); while (request_q.size() != 0 || grant_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request driver: hold the item until taken, then pause or present the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold valid and payload until the handshake completes
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (request_q.size() != 0) begin
      in_valid <= 1'b1;
      in_mode <= request_q[0].mode;
      in_free_index <= request_q[0].index;
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: stall at random while idling is on.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check each grant against the oldest expectation, then predict
  // the grant of any request taken at this edge.
  always @(posedge clk) begin : watch
    slot_grant_t seen;
    slot_grant_t want;
    req_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      seen.slot = out_slot_index;
      seen.cpu_addr = out_cpu_address;
      seen.gpu_addr = out_gpu_address;
      seen.status = out_status;
      if (grant_q.size() == 0) begin
        flag_error($sformatf("unexpected result slot %0d cpu %h gpu %h status %0d",
                             seen.slot, seen.cpu_addr, seen.gpu_addr, seen.status));
      end else begin
        want = grant_q.pop_front();
        if (seen.slot !== want.slot || seen.cpu_addr !== want.cpu_addr ||
            seen.gpu_addr !== want.gpu_addr || seen.status !== want.status) begin
          flag_error($sformatf(
            "expected slot %0d cpu %h gpu %h status %0d, got slot %0d cpu %h gpu %h status %0d",
            want.slot, want.cpu_addr, want.gpu_addr, want.status,
            seen.slot, seen.cpu_addr, seen.gpu_addr, seen.status));
        end
      end
    end
    if (rst_n && in_valid && in_ready) grant_q.push_back(serve_request(request_q.pop_front()));
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: fresh slots, recycling in order, the top index
    // and index zero through the list, and a double free handed out twice.
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 1023);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_FREE, 1023);
    push_req(MODE_FREE, 0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_FREE, 5);
    push_req(MODE_FREE, 5);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 0);
    wait_idle();

    // Two slots, all-ones bases and a stride of 4096: addresses wrap, the
    // bump counter is already past capacity so the heap is full, and frees
    // out of range and beyond the list depth are dropped.
    configure('1, '1, 4096, 2, 1'b1);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_FREE, 1023);
    push_req(MODE_FREE, 1);
    push_req(MODE_FREE, 0);
    push_req(MODE_FREE, 1);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 0);
    wait_idle();

    // Zero capacity: every allocate is full and every free is dropped.
    configure('0, '0, 0, 0, 1'b0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_FREE, 0);
    wait_idle();

    // Small heap, balanced traffic with idling on both sides.
    configure({$urandom, $urandom}, {$urandom, $urandom}, 32, 16, 1'b1);
    queue_requests(200, 50);
    wait_idle();

    // Allocate-heavy stretch without any idling: push the bump counter up.
    idle_on = 1'b0;
    configure({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 4096), 64, 1'b1);
    queue_requests(150, 70);
    wait_idle();

    // Lower the capacity: queued indices above it still come back out,
    // fresh ones stop at once.
    idle_on = 1'b1;
    configure({$urandom, $urandom}, {$urandom, $urandom}, 4095, 8, 1'b0);
    queue_requests(150, 50);
    wait_idle();

    // Capacity above the built depth is clamped; every index is in range.
    configure('1, '1, 4096, 2047, 1'b1);
    queue_requests(250, 45);
    wait_idle();

    // Single slot with zero stride.
    configure({$urandom, $urandom}, {$urandom, $urandom}, 0, 1, 1'b1);
    queue_requests(100, 50);
    wait_idle();

    // Full heap in two halves; the sender pauses in between until every
    // grant has come back, with no configuration change.
    configure({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 4096), 1024, 1'b1);
    queue_requests(150, 55);
    wait_idle();
    queue_requests(150, 55);
    wait_idle();

    // Random small capacity and visibility.
    configure({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 4096),
              $urandom_range(1, 32), 1'($urandom_range(0, 1)));
    queue_requests(200, 50);
    wait_idle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
